/* rtl/bpa_pkg.sv */
// Buddy page allocator package: sizes, status codes and the structs that
// travel between the controller and its two stores. No dependencies.
package bpa_pkg;

  localparam int MAX_ORDER       = 16;
  localparam int PAGE_BYTES_LOG2 = 12;
  localparam int FREE_LIST_DEPTH = 64;
  localparam int ALLOC_SLOTS     = 64;

  localparam int ORD_W      = $clog2(MAX_ORDER + 2);
  localparam int IDX_W      = $clog2(FREE_LIST_DEPTH);
  localparam int CNT_W      = $clog2(FREE_LIST_DEPTH + 1);
  localparam int FL_AW      = ORD_W + IDX_W;
  localparam int FL_ENTRIES = (MAX_ORDER + 1) * FREE_LIST_DEPTH;
  localparam int SLOT_W     = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;
  localparam int DRY_W      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int PG_W       = 16;
  localparam int REQ_W      = 31;
  localparam int ST_W       = 3;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_TOO_LARGE  = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_MEMORY  = 3'd2;
  localparam logic [ST_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [ST_W-1:0] ST_OVERFLOW   = 3'd5;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // free count update codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_SET1 = 2'd3;

  localparam logic [FL_AW-1:0] TOP0_ADDR = {ORD_W'(MAX_ORDER), IDX_W'(0)};

  typedef struct packed {
    logic             command;
    logic [REQ_W-1:0] request_bytes;
    logic [PG_W-1:0]  free_start;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PG_W-1:0]  start_page;
    logic [ORD_W-1:0] block_order;
  } out_t;

  typedef logic [MAX_ORDER:0][CNT_W-1:0] cnt_vec_t;

  typedef struct packed {
    logic             we;
    logic [FL_AW-1:0] waddr;
    logic [PG_W-1:0]  wdata;
    logic [FL_AW-1:0] raddr;
    logic [1:0]       cnt_op;
    logic [ORD_W-1:0] cnt_ord;
  } fl_req_t;

  typedef struct packed {
    logic [ORD_W-1:0] order;
    logic [PG_W-1:0]  start;
  } at_entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    at_entry_t         wdata;
    logic [SLOT_W-1:0] raddr;
    logic              vset;
    logic              vclr;
    logic [SLOT_W-1:0] vslot;
  } at_req_t;

endpackage

/* rtl/bpa_free_lists.sv */
// Per-order free lists: one synchronous RAM of block starts plus the
// per-order fill counts. Depends on bpa_pkg.
module bpa_free_lists (
  input  logic             clk,
  input  logic             rst_n,
  input  bpa_pkg::fl_req_t req,
  output logic [15:0]      rdata,
  output bpa_pkg::cnt_vec_t cnt
);
  import bpa_pkg::*;

  logic [PG_W-1:0] mem [0:FL_ENTRIES-1];
  logic [PG_W-1:0] q_r;
  logic            rd_zero_r;
  logic            top0_ok_r;
  cnt_vec_t        cnt_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    q_r <= mem[req.raddr];
  end

  // top list's first entry reads as page 0 until it is first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top0_ok_r <= 1'b0;
      rd_zero_r <= 1'b0;
    end else begin
      if (req.we && req.waddr == TOP0_ADDR) begin
        top0_ok_r <= 1'b1;
      end
      rd_zero_r <= (req.raddr == TOP0_ADDR) && !top0_ok_r;
    end
  end

  // top order starts with one block, all others empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= {CNT_W'(1), {(MAX_ORDER * CNT_W){1'b0}}};
    end else begin
      case (req.cnt_op)
        CNT_INC:  cnt_r[req.cnt_ord] <= cnt_r[req.cnt_ord] + CNT_W'(1);
        CNT_DEC:  cnt_r[req.cnt_ord] <= cnt_r[req.cnt_ord] - CNT_W'(1);
        CNT_SET1: cnt_r[req.cnt_ord] <= CNT_W'(1);
        default:  ;
      endcase
    end
  end

  assign rdata = rd_zero_r ? '0 : q_r;
  assign cnt   = cnt_r;

endmodule

/* rtl/bpa_alloc_table.sv */
// Allocation record table: RAM of start/order per slot, valid flops and
// the first-free-slot encoder. Depends on bpa_pkg.
module bpa_alloc_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bpa_pkg::at_req_t             req,
  output bpa_pkg::at_entry_t           rdata,
  output logic                         rvalid,
  output logic [bpa_pkg::SLOT_W-1:0]   free_slot,
  output logic                         full
);
  import bpa_pkg::*;

  at_entry_t              mem [0:ALLOC_SLOTS-1];
  at_entry_t              q_r;
  logic                   qv_r;
  logic [ALLOC_SLOTS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    q_r <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      qv_r    <= 1'b0;
    end else begin
      if (req.vset) begin
        valid_r[req.vslot] <= 1'b1;
      end
      if (req.vclr) begin
        valid_r[req.vslot] <= 1'b0;
      end
      qv_r <= valid_r[req.raddr];
    end
  end

  always_comb begin
    free_slot = '0;
    full      = 1'b1;
    for (int k = ALLOC_SLOTS - 1; k >= 0; k--) begin
      if (!valid_r[k]) begin
        free_slot = SLOT_W'(k);
        full      = 1'b0;
      end
    end
  end

  assign rdata  = q_r;
  assign rvalid = qv_r;

endmodule

/* rtl/buddy_page_allocator_unit.sv */
// Buddy page allocator, top level: command sequencer over the free-list
// RAM and the allocation table. Depends on bpa_pkg, bpa_free_lists and
// bpa_alloc_table.
//
// Use: drive in_data and raise start; the transaction is taken on an edge
// where start is high and busy is low. busy stays high until the result
// is presented. The result appears on out_data for exactly one cycle with
// out_valid high; the receiver cannot hold it off.
// Allocate: check, read the list front, read its last entry, pop, then
// one split step per level (at most MAX_ORDER) before the result.
// Allocate errors answer from the check step. Free: the table is scanned
// slot by slot from slot 0, each buddy list is searched entry by entry,
// then the check step and the merge, which moves each merged buddy out of
// its list. An unknown start answers after the whole table is scanned; an
// overflow answers from the check step, skipping the merge. The table scan
// and the single read port of the free-list RAM set these sequences.
// One command is in flight at a time; a new one may be taken in the cycle
// its predecessor's result is shown.
// Reset: the top order holds one block at page 0, all other lists and the
// table are empty. No clearing pass is needed.
module buddy_page_allocator_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bpa_pkg::in_t  in_data,
  output logic          out_valid,
  output bpa_pkg::out_t out_data
);
  import bpa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_A_S   = 4'd2;
  localparam logic [3:0] S_A_L   = 4'd3;
  localparam logic [3:0] S_SPLIT = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_DRY   = 4'd6;
  localparam logic [3:0] S_FIND  = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_MRG   = 4'd9;
  localparam logic [3:0] S_MV    = 4'd10;

  logic [3:0]        state_r, state_nxt;
  in_t               cmd_r, cmd_nxt;
  logic [ORD_W-1:0]  ord_r, ord_nxt;
  logic [ORD_W-1:0]  n_r, n_nxt;
  logic [ORD_W-1:0]  p_r, p_nxt;
  logic [PG_W-1:0]   s_r, s_nxt;
  logic [PG_W-1:0]   t_r, t_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  idx_r [0:MAX_ORDER-1];
  logic              idx_we;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  fl_req_t           fl_req;
  logic [PG_W-1:0]   fl_q;
  cnt_vec_t          cnt;
  at_req_t           at_req;
  at_entry_t         at_q;
  logic              at_qv;
  logic [SLOT_W-1:0] free_slot;
  logic              tab_full;

  logic [ORD_W-1:0]  req_ord;
  logic [ORD_W-1:0]  src_ord;
  logic              src_found;
  logic [ORD_W-1:0]  nm1;
  logic [PG_W-1:0]   buddy;
  logic [ORD_W-1:0]  fo;

  bpa_free_lists u_fl (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fl_req),
    .rdata (fl_q),
    .cnt   (cnt)
  );

  bpa_alloc_table u_at (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (at_req),
    .rdata     (at_q),
    .rvalid    (at_qv),
    .free_slot (free_slot),
    .full      (tab_full)
  );

  // smallest order whose block holds the request
  always_comb begin
    req_ord = '0;
    for (int k = 0; k <= MAX_ORDER; k++) begin
      if ({1'b0, in_data.request_bytes} > (32'd1 << (k + PAGE_BYTES_LOG2))) begin
        req_ord = req_ord + ORD_W'(1);
      end
    end
  end

  always_comb begin
    src_ord   = '0;
    src_found = 1'b0;
    for (int k = MAX_ORDER; k >= 0; k--) begin
      if (ORD_W'(k) >= ord_r && cnt[k] != '0) begin
        src_ord   = ORD_W'(k);
        src_found = 1'b1;
      end
    end
  end

  assign nm1   = n_r - ORD_W'(1);
  assign buddy = t_r ^ (PG_W'(1) << p_r);
  assign fo    = (at_q.order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : at_q.order;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    ord_nxt       = ord_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    slot_nxt      = slot_r;
    i_nxt         = i_r;
    idx_we        = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    fl_req        = '0;
    at_req        = '0;
    at_req.vslot  = slot_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_data;
          ord_nxt   = req_ord;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (cmd_r.command == CMD_ALLOC) begin
          if (ord_r > ORD_W'(MAX_ORDER)) begin
            out_nxt       = '{ST_TOO_LARGE, '0, '0};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (tab_full) begin
            out_nxt       = '{ST_TABLE_FULL, '0, '0};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (!src_found) begin
            out_nxt       = '{ST_NO_MEMORY, '0, '0};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            n_nxt        = src_ord;
            slot_nxt     = free_slot;
            fl_req.raddr = {src_ord, IDX_W'(0)};
            state_nxt    = S_A_S;
          end
        end else begin
          slot_nxt     = '0;
          at_req.raddr = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_A_S: begin
        s_nxt        = fl_q;
        fl_req.raddr = {n_r, IDX_W'(cnt[n_r] - CNT_W'(1))};
        state_nxt    = S_A_L;
      end
      S_A_L: begin
        // last entry moves into the front hole
        fl_req.we      = 1'b1;
        fl_req.waddr   = {n_r, IDX_W'(0)};
        fl_req.wdata   = fl_q;
        fl_req.cnt_op  = CNT_DEC;
        fl_req.cnt_ord = n_r;
        state_nxt      = S_SPLIT;
      end
      S_SPLIT: begin
        if (n_r > ord_r) begin
          // lower list is empty here: it ends up holding only the upper half
          fl_req.we      = 1'b1;
          fl_req.waddr   = {nm1, IDX_W'(0)};
          fl_req.wdata   = s_r + (PG_W'(1) << nm1);
          fl_req.cnt_op  = CNT_SET1;
          fl_req.cnt_ord = nm1;
          n_nxt          = nm1;
        end else begin
          at_req.we     = 1'b1;
          at_req.waddr  = slot_r;
          at_req.wdata  = '{ord_r, s_r};
          at_req.vset   = 1'b1;
          out_nxt       = '{ST_OK, s_r, ord_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        at_req.raddr = slot_r + SLOT_W'(1);
        if (at_qv && at_q.start == cmd_r.free_start) begin
          s_nxt     = at_q.start;
          t_nxt     = at_q.start;
          ord_nxt   = fo;
          p_nxt     = fo;
          state_nxt = S_DRY;
        end else if (slot_r == SLOT_W'(ALLOC_SLOTS - 1)) begin
          out_nxt       = '{ST_NOT_FOUND, '0, '0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      S_DRY: begin
        if (p_r == ORD_W'(MAX_ORDER) || cnt[p_r] == '0) begin
          state_nxt = S_FCHK;
        end else begin
          i_nxt        = '0;
          fl_req.raddr = {p_r, IDX_W'(0)};
          state_nxt    = S_FIND;
        end
      end
      S_FIND: begin
        if (fl_q == buddy) begin
          idx_we    = 1'b1;
          t_nxt     = t_r & ~(PG_W'(1) << p_r);
          p_nxt     = p_r + ORD_W'(1);
          state_nxt = S_DRY;
        end else if ({1'b0, i_r} + CNT_W'(1) >= cnt[p_r]) begin
          state_nxt = S_FCHK;
        end else begin
          i_nxt        = i_r + IDX_W'(1);
          fl_req.raddr = {p_r, i_r + IDX_W'(1)};
        end
      end
      S_FCHK: begin
        if (cnt[p_r] >= CNT_W'(FREE_LIST_DEPTH)) begin
          out_nxt       = '{ST_OVERFLOW, '0, '0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          at_req.vclr = 1'b1;
          n_nxt       = ord_r;
          state_nxt   = S_MRG;
        end
      end
      S_MRG: begin
        if (n_r < p_r) begin
          fl_req.raddr = {n_r, IDX_W'(cnt[n_r] - CNT_W'(1))};
          state_nxt    = S_MV;
        end else begin
          fl_req.we      = 1'b1;
          fl_req.waddr   = {p_r, IDX_W'(cnt[p_r])};
          fl_req.wdata   = t_r;
          fl_req.cnt_op  = CNT_INC;
          fl_req.cnt_ord = p_r;
          out_nxt        = '{ST_OK, s_r, ord_r};
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_MV: begin
        fl_req.we      = 1'b1;
        fl_req.waddr   = {n_r, idx_r[n_r[DRY_W-1:0]]};
        fl_req.wdata   = fl_q;
        fl_req.cnt_op  = CNT_DEC;
        fl_req.cnt_ord = n_r;
        n_nxt          = n_r + ORD_W'(1);
        state_nxt      = S_MRG;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    ord_r  <= ord_nxt;
    n_r    <= n_nxt;
    p_r    <= p_nxt;
    s_r    <= s_nxt;
    t_r    <= t_nxt;
    slot_r <= slot_nxt;
    i_r    <= i_nxt;
    out_r  <= out_nxt;
    if (idx_we) begin
      idx_r[p_r[DRY_W-1:0]] <= i_r;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_take_to_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_CHK))
    else $error("accepted transaction did not enter the check step");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_L) |-> (cnt[n_r] != '0))
    else $error("pop from an empty free list");

  a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND) |-> (p_r < ORD_W'(MAX_ORDER)))
    else $error("buddy search past the top order");

endmodule

/* tb/buddy_page_allocator_unit_tb.sv */
// Testbench for buddy_page_allocator_unit: random and directed allocate/free
// transactions checked against an in-bench buddy allocator predictor.
// Depends on bpa_pkg and the RTL of buddy_page_allocator_unit.
`timescale 1ns / 1ps

module buddy_page_allocator_unit_tb;
  import bpa_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  in_t   in_data;
  logic  out_valid;
  out_t  out_data;

  buddy_page_allocator_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // predictor state
  logic [PG_W-1:0] fl_page [MAX_ORDER+1][FREE_LIST_DEPTH];
  int              fl_fill [MAX_ORDER+1];
  logic [PG_W-1:0] tbl_start [ALLOC_SLOTS];
  int              tbl_order [ALLOC_SLOTS];
  bit              tbl_used [ALLOC_SLOTS];

  in_t  pending_cmds[$];
  out_t expected_results[$];
  int   mismatches;
  int   cycles;
  bit   stim_done;
  int   gap;

  function automatic void fl_push(int o, logic [PG_W-1:0] s);
    if (fl_fill[o] < FREE_LIST_DEPTH) begin
      fl_page[o][fl_fill[o]] = s;
      fl_fill[o]++;
    end
  endfunction

  function automatic void fl_drop(int o, int i);
    if (i < fl_fill[o]) begin
      fl_page[o][i] = fl_page[o][fl_fill[o]-1];
      fl_fill[o]--;
    end
  endfunction

  function automatic int fl_search(int o, logic [PG_W-1:0] s);
    for (int i = 0; i < fl_fill[o]; i++)
      if (fl_page[o][i] == s) return i;
    return -1;
  endfunction

  function automatic out_t allocator_predict(in_t c);
    out_t r;
    int ord, n, slot, p, idx;
    logic [PG_W-1:0] s, t;
    longint req;
    r = '0;
    if (c.command == CMD_ALLOC) begin
      req = c.request_bytes;
      ord = 0;
      while (ord <= MAX_ORDER && req > (longint'(1) << (ord + PAGE_BYTES_LOG2))) ord++;
      if (ord > MAX_ORDER) begin
        r.status = ST_TOO_LARGE;
        return r;
      end
      slot = 0;
      while (slot < ALLOC_SLOTS && tbl_used[slot]) slot++;
      if (slot >= ALLOC_SLOTS) begin
        r.status = ST_TABLE_FULL;
        return r;
      end
      n = ord;
      while (n <= MAX_ORDER && fl_fill[n] == 0) n++;
      if (n > MAX_ORDER) begin
        r.status = ST_NO_MEMORY;
        return r;
      end
      s = fl_page[n][0];
      fl_drop(n, 0);
      while (n > ord) begin
        n--;
        fl_push(n, s);
        fl_push(n, s + PG_W'(1 << n));
        s = fl_page[n][0];
        fl_drop(n, 0);
      end
      tbl_used[slot] = 1;
      tbl_start[slot] = s;
      tbl_order[slot] = ord;
      r.status = ST_OK;
      r.start_page = s;
      r.block_order = ORD_W'(ord);
    end else begin
      slot = 0;
      while (slot < ALLOC_SLOTS && !(tbl_used[slot] && tbl_start[slot] == c.free_start))
        slot++;
      if (slot >= ALLOC_SLOTS) begin
        r.status = ST_NOT_FOUND;
        return r;
      end
      p = (tbl_order[slot] > MAX_ORDER) ? MAX_ORDER : tbl_order[slot];
      s = tbl_start[slot];
      t = s;
      // dry run finds the list that receives the merged block
      while (p < MAX_ORDER && fl_search(p, t ^ PG_W'(1 << p)) >= 0) begin
        t &= ~PG_W'(1 << p);
        p++;
      end
      if (fl_fill[p] >= FREE_LIST_DEPTH) begin
        r.status = ST_OVERFLOW;
        return r;
      end
      tbl_used[slot] = 0;
      p = tbl_order[slot];
      t = s;
      while (p < MAX_ORDER) begin
        idx = fl_search(p, t ^ PG_W'(1 << p));
        if (idx < 0) break;
        fl_drop(p, idx);
        t &= ~PG_W'(1 << p);
        p++;
      end
      fl_push(p, t);
      r.status = ST_OK;
      r.start_page = s;
      r.block_order = ORD_W'(tbl_order[slot]);
    end
    return r;
  endfunction

  function automatic in_t mk_alloc(logic [REQ_W-1:0] b);
    in_t c;
    c = '0;
    c.command = CMD_ALLOC;
    c.request_bytes = b;
    c.free_start = PG_W'($urandom);
    return c;
  endfunction

  function automatic in_t mk_free(logic [PG_W-1:0] s);
    in_t c;
    c = '0;
    c.command = CMD_FREE;
    c.request_bytes = REQ_W'($urandom);
    c.free_start = s;
    return c;
  endfunction

  // mostly small requests so the table fills and frees merge often
  function automatic logic [REQ_W-1:0] rand_bytes();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return REQ_W'($urandom_range(0, 1 << (PAGE_BYTES_LOG2 + 3)));
    if (k < 90) return REQ_W'($urandom_range(0, 1 << (PAGE_BYTES_LOG2 + 10)));
    if (k < 95) return REQ_W'($urandom);
    return REQ_W'(1 << (PAGE_BYTES_LOG2 + MAX_ORDER)) + REQ_W'($urandom_range(0, 1));
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    int sel;
    logic [PG_W-1:0] pg;
    rst_n = 0;
    start = 0;
    in_data = '0;
    mismatches = 0;
    stim_done = 0;
    gap = 0;
    for (int o = 0; o <= MAX_ORDER; o++) fl_fill[o] = 0;
    fl_fill[MAX_ORDER] = 1;
    fl_page[MAX_ORDER][0] = '0;
    for (int i = 0; i < ALLOC_SLOTS; i++) tbl_used[i] = 0;

    // directed: free on empty table, whole memory, too large, zero bytes, extremes
    pending_cmds.push_back(mk_free(16'hFFFF));
    pending_cmds.push_back(mk_alloc(REQ_W'(1 << (PAGE_BYTES_LOG2 + MAX_ORDER))));
    pending_cmds.push_back(mk_alloc(0));                   // no memory
    pending_cmds.push_back(mk_free(16'h0000));
    pending_cmds.push_back(mk_alloc(REQ_W'((1 << (PAGE_BYTES_LOG2 + MAX_ORDER)) + 1)));
    pending_cmds.push_back(mk_alloc('1));
    pending_cmds.push_back(mk_alloc(0));                   // full split to order 0
    pending_cmds.push_back(mk_alloc(1));
    pending_cmds.push_back(mk_alloc(REQ_W'(1 << PAGE_BYTES_LOG2)));
    pending_cmds.push_back(mk_alloc(REQ_W'((1 << PAGE_BYTES_LOG2) + 1)));
    pending_cmds.push_back(mk_free(16'h0001));
    pending_cmds.push_back(mk_free(16'h0000));
    pending_cmds.push_back(mk_free(16'h0005));             // not found
    pending_cmds.push_back(mk_free(16'h0002));
    pending_cmds.push_back(mk_free(16'h0004));
    // table full: 65 order-0 allocations, then release them all
    for (int i = 0; i < ALLOC_SLOTS + 1; i++) pending_cmds.push_back(mk_alloc(0));
    for (int i = 0; i < ALLOC_SLOTS; i++) pending_cmds.push_back(mk_free(PG_W'(i)));

    // random: frees mostly target small aligned starts, a few anywhere
    for (int i = 0; i < 1500; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        pending_cmds.push_back(mk_alloc(rand_bytes()));
      end else if (sel < 92) begin
        // free a start that is a plausible block: aligned small offsets
        pg = PG_W'($urandom_range(0, 127)) << $urandom_range(0, 3);
        pending_cmds.push_back(mk_free(pg));
      end else begin
        pending_cmds.push_back(mk_free(PG_W'($urandom)));
      end
    end
    // drain: free the low pages so the lists merge back up
    for (int i = 0; i < 256; i += 1) pending_cmds.push_back(mk_free(PG_W'(i)));
    stim_done = 1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
    end else if (start && !busy) begin
      // transaction taken at this edge
      expected_results.push_back(allocator_predict(in_data));
      if (pending_cmds.size() > 0 && $urandom_range(0, 3) != 0) begin
        in_data <= pending_cmds.pop_front();
        start <= 1;
      end else begin
        start <= 0;
        gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 3);
      end
    end else if (!start) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (pending_cmds.size() > 0) begin
        in_data <= pending_cmds.pop_front();
        start <= 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = expected_results.pop_front();
        if (out_data.status !== e.status || out_data.start_page !== e.start_page ||
            out_data.block_order !== e.block_order) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d pg=%0d ord=%0d got st=%0d pg=%0d ord=%0d",
                     e.status, e.start_page, e.block_order,
                     out_data.status, out_data.start_page, out_data.block_order);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    while (!(stim_done && pending_cmds.size() == 0 && !start &&
             expected_results.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
    end else begin
      repeat (200) @(posedge clk);
      if (mismatches == 0 && expected_results.size() == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

endmodule

/* buddy_page_allocator_unit.f */
rtl/bpa_pkg.sv
rtl/bpa_free_lists.sv
rtl/bpa_alloc_table.sv
rtl/buddy_page_allocator_unit.sv
tb/buddy_page_allocator_unit_tb.sv
